// File: sv/tli_pkg.sv
// ----------------------------------------------------------------------------
// tli_pkg
// Shared types and constants for the 1-D piecewise-linear lookup table.
// ----------------------------------------------------------------------------
package tli_pkg;

  localparam int unsigned MAX_POINTS_DEF = 256;
  localparam int unsigned CFG_ADDR_W     = 3;
  localparam int unsigned DIV_STEPS      = 32;
  localparam int unsigned DIV_CNT_W      = $clog2(DIV_STEPS);

  // request actions
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // result status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  // configuration register indexes
  localparam logic REG_POINT_COUNT = 1'b0;

  // controller -> datapath
  typedef struct packed {
    logic wr_en;     // store one table entry
    logic start;     // set up a query
    logic scan;      // advance the table scan
    logic cap_rd;    // take result straight from the entry read
    logic cap_ops;   // capture interpolation operands
    logic mul;       // product into divider
    logic div_step;  // one restoring division step
    logic fin;       // apply the signed quotient to y0
    logic ld_out;    // move result into the output register
  } tli_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;     // point count is zero
    logic hit;       // entry read is at or above the query
    logic last;      // entry read is the last one in use
    logic first;     // entry read is entry 0
    logic div_last;  // final division step
  } tli_sts_t;

endpackage

// File: sv/tli_if.sv
// ----------------------------------------------------------------------------
// tli_req_if / tli_rsp_if
// Valid/ready channels for requests into and results out of the lookup table.
// ----------------------------------------------------------------------------
interface tli_req_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [7:0]         entry_index;
  logic signed [31:0] entry_x;
  logic signed [31:0] entry_y;
  logic signed [31:0] query_x;

  modport source (output valid, action, entry_index, entry_x, entry_y, query_x,
                  input ready);
  modport sink   (input valid, action, entry_index, entry_x, entry_y, query_x,
                  output ready);
endinterface

interface tli_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] y_value;
  logic               status;

  modport source (output valid, y_value, status, input ready);
  modport sink   (input valid, y_value, status, output ready);
endinterface

// File: sv/tli_datapath.sv
// ----------------------------------------------------------------------------
// tli_datapath
// Breakpoint memories, scan pipeline, multiplier, serial divider, result regs.
// ----------------------------------------------------------------------------
module tli_datapath #(
  parameter int unsigned MaxPoints = tli_pkg::MAX_POINTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tli_pkg::tli_cmd_t  cmd_i,
  output tli_pkg::tli_sts_t  sts_o,
  input  logic [8:0]         point_count_i,
  input  logic [7:0]         entry_index_i,
  input  logic signed [31:0] entry_x_i,
  input  logic signed [31:0] entry_y_i,
  input  logic signed [31:0] query_x_i,
  output logic signed [31:0] y_value_o,
  output logic               status_o
);

  localparam int unsigned AddrW = $clog2(MaxPoints);
  localparam int unsigned CntW  = tli_pkg::DIV_CNT_W;

  logic [31:0] x_mem [MaxPoints];
  logic [31:0] y_mem [MaxPoints];

  logic signed [31:0] x_rd_q, y_rd_q;
  logic [AddrW-1:0]   rd_addr_q, didx_q, last_idx_q;
  logic               iss_q, dvld_q;
  logic signed [31:0] q_q, px_q;
  logic [31:0]        py_q;
  logic [31:0]        t_q, d_q, mag_q, y0_q;
  logic               neg_q;
  logic [31:0]        rem_q, low_q;
  logic [CntW-1:0]    div_cnt_q;
  logic [31:0]        res_q, y_out_q;
  logic               status_q, st_out_q;

  logic              idx_ok;
  logic [AddrW-1:0]  wr_addr;
  logic [31:0]       n_lim, n_m1;
  logic [32:0]       t_ext, d_ext, dy_ext, dy_neg;
  logic [63:0]       prod;
  logic [32:0]       dv_tmp, dv_sub;
  logic              dv_ge;

  assign idx_ok  = 32'(entry_index_i) < 32'(MaxPoints);
  assign wr_addr = AddrW'(entry_index_i);
  assign n_lim   = (32'(point_count_i) > 32'(MaxPoints)) ? 32'(MaxPoints)
                                                          : 32'(point_count_i);
  assign n_m1    = n_lim - 32'd1;

  // operands; x0 < q <= x1 in the interior case
  assign t_ext  = {q_q[31], q_q} - {px_q[31], px_q};
  assign d_ext  = {x_rd_q[31], x_rd_q} - {px_q[31], px_q};
  assign dy_ext = {y_rd_q[31], y_rd_q} - {py_q[31], py_q};
  assign dy_neg = 33'd0 - dy_ext;
  // unsigned 32x32 product, zero-extended operands
  assign prod   = 64'(t_q) * 64'(mag_q);

  assign dv_tmp = {rem_q, low_q[31]};
  assign dv_sub = dv_tmp - {1'b0, d_q};
  assign dv_ge  = dv_tmp >= {1'b0, d_q};

  // table memories, one write and one registered read port each
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && idx_ok) begin
      x_mem[wr_addr] <= entry_x_i;
      y_mem[wr_addr] <= entry_y_i;
    end
    x_rd_q <= x_mem[rd_addr_q];
    y_rd_q <= y_mem[rd_addr_q];
  end

  // scan control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_addr_q  <= '0;
      didx_q     <= '0;
      last_idx_q <= '0;
      iss_q      <= 1'b0;
      dvld_q     <= 1'b0;
      div_cnt_q  <= '0;
    end else if (cmd_i.start) begin
      rd_addr_q  <= '0;
      last_idx_q <= AddrW'(n_m1);
      iss_q      <= 1'b1;
      dvld_q     <= 1'b0;
    end else if (cmd_i.scan) begin
      didx_q <= rd_addr_q;
      dvld_q <= iss_q;
      if (iss_q) begin
        if (rd_addr_q == last_idx_q) begin
          iss_q <= 1'b0;
        end else begin
          rd_addr_q <= rd_addr_q + AddrW'(1);
        end
      end
    end else if (cmd_i.mul) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + CntW'(1);
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      q_q      <= query_x_i;
      res_q    <= '0;
      status_q <= (point_count_i == '0) ? tli_pkg::STATUS_EMPTY : tli_pkg::STATUS_OK;
    end
    if (cmd_i.scan && dvld_q) begin
      px_q <= x_rd_q;
      py_q <= y_rd_q;
    end
    if (cmd_i.cap_rd) begin
      res_q <= y_rd_q;
    end
    if (cmd_i.cap_ops) begin
      t_q   <= t_ext[31:0];
      d_q   <= d_ext[31:0];
      neg_q <= dy_ext[32];
      mag_q <= dy_ext[32] ? dy_neg[31:0] : dy_ext[31:0];
      y0_q  <= py_q;
    end
    // product high word is below the divisor, so 32 steps give the quotient
    if (cmd_i.mul) begin
      rem_q <= prod[63:32];
      low_q <= prod[31:0];
    end
    if (cmd_i.div_step) begin
      rem_q <= dv_ge ? dv_sub[31:0] : dv_tmp[31:0];
      low_q <= {low_q[30:0], dv_ge};
    end
    if (cmd_i.fin) begin
      res_q <= neg_q ? (y0_q - low_q) : (y0_q + low_q);
    end
    if (cmd_i.ld_out) begin
      y_out_q  <= res_q;
      st_out_q <= status_q;
    end
  end

  assign sts_o.empty    = (point_count_i == '0);
  assign sts_o.hit      = dvld_q && (x_rd_q >= q_q);
  assign sts_o.last     = dvld_q && (didx_q == last_idx_q);
  assign sts_o.first    = (didx_q == '0);
  assign sts_o.div_last = (div_cnt_q == CntW'(tli_pkg::DIV_STEPS - 1));

  assign y_value_o = y_out_q;
  assign status_o  = st_out_q;

endmodule

// File: sv/tli_ctrl.sv
// ----------------------------------------------------------------------------
// tli_ctrl
// Sequencer for loads, table scan, multiply, divide and result handoff.
// ----------------------------------------------------------------------------
module tli_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic              req_action_i,
  output logic              req_ready_o,
  input  logic              rsp_ready_i,
  output logic              rsp_valid_o,
  output tli_pkg::tli_cmd_t cmd_o,
  input  tli_pkg::tli_sts_t sts_i
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_FIN   = 6'b010000,
    ST_WRITE = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;
  logic   out_free;

  assign out_free = !out_vld_q || rsp_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          if (req_action_i == tli_pkg::ACT_LOAD) begin
            cmd_o.wr_en = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            state_d     = sts_i.empty ? ST_WRITE : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.hit) begin
          if (sts_i.first) begin
            cmd_o.cap_rd = 1'b1;
            state_d      = ST_WRITE;
          end else begin
            cmd_o.cap_ops = 1'b1;
            state_d       = ST_MUL;
          end
        end else if (sts_i.last) begin
          cmd_o.cap_rd = 1'b1;
          state_d      = ST_WRITE;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = ST_WRITE;
      end
      ST_WRITE: begin
        if (out_free) begin
          cmd_o.ld_out = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.ld_out) begin
      out_vld_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = out_vld_q;

endmodule

// File: sv/table_linear_interpolation.sv
// ----------------------------------------------------------------------------
// table_linear_interpolation
// 1-D piecewise-linear lookup over a table of signed Q16.16 breakpoints.
// ----------------------------------------------------------------------------
// Usage:
//   req_i (valid/ready) carries one request. action LOAD stores (entry_x,
//   entry_y) at entry_index and produces no result; positions at or above
//   MaxPoints are dropped. action QUERY evaluates query_x over the first
//   point_count entries (at most MaxPoints) and produces one result on rsp_o.
//   The APB port holds point_count (register 0); write it only while idle.
//   Query results on rsp_o:
//     empty table                  : y_value 0, status EMPTY
//     clamped (below / above)      : y of the first / last entry, status OK
//     interior                     : interpolated y, status OK
//   The scan reads one entry per cycle from the breakpoint memories; the
//   quotient comes from a restoring divider at one bit per cycle (32 steps).
//   One request is in work at a time.
//   A finished result sits in an output register, so the next request is
//   taken while rsp_o is stalled; a second result waits until it drains.
//   Reset clears the controller, the output valid and point_count. The
//   tables are not cleared: reading a never-written entry gives junk.
// ----------------------------------------------------------------------------
module table_linear_interpolation #(
  parameter int unsigned MaxPoints = tli_pkg::MAX_POINTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  tli_req_if.sink                         req_i,
  tli_rsp_if.source                       rsp_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tli_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  tli_pkg::tli_cmd_t cmd;
  tli_pkg::tli_sts_t sts;

  logic [8:0] point_count_q;
  logic       reg_sel;

  // --- configuration port ---------------------------------------------------
  // word index sits above the byte offset; one register at word 0
  assign reg_sel = (paddr[2] == tli_pkg::REG_POINT_COUNT);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {23'd0, point_count_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= '0;
    end else if (psel && penable && pwrite && reg_sel) begin
      point_count_q <= pwdata[8:0];
    end
  end

  // --- controller -----------------------------------------------------------
  tli_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_action_i (req_i.action),
    .req_ready_o  (req_i.ready),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_valid_o  (rsp_o.valid),
    .cmd_o        (cmd),
    .sts_i        (sts)
  );

  // --- datapath -------------------------------------------------------------
  tli_datapath #(
    .MaxPoints (MaxPoints)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .point_count_i (point_count_q),
    .entry_index_i (req_i.entry_index),
    .entry_x_i     (req_i.entry_x),
    .entry_y_i     (req_i.entry_y),
    .query_x_i     (req_i.query_x),
    .y_value_o     (rsp_o.y_value),
    .status_o      (rsp_o.status)
  );

  // --- assertions -----------------------------------------------------------
  // a load never produces a result
  a_load_no_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && req_i.action == tli_pkg::ACT_LOAD && !rsp_o.valid)
    |=> !rsp_o.valid)
    else $error("result appeared after a load request");

  // empty-table query answers with EMPTY and zero, via ST_WRITE and the output register
  a_empty_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && req_i.action == tli_pkg::ACT_QUERY &&
     point_count_q == '0 && !rsp_o.valid)
    |=> ##1 (rsp_o.valid && rsp_o.status == tli_pkg::STATUS_EMPTY &&
             rsp_o.y_value == '0))
    else $error("empty-table query not answered as expected");

  // no new request is taken while a query is being worked on
  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> !(cmd.scan || cmd.mul || cmd.div_step || cmd.fin))
    else $error("request ready while query in progress");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 1-D piecewise-linear lookup table.
// A queue of pending requests (table loads and lookups) feeds a clocked
// driver; a clocked monitor compares each result with the value that the
// bench's own Q16.16 predictor worked out when the lookup was accepted.
// point_count is set over APB between phases, only once the block is idle.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CLK_PERIOD     = 4;
  localparam int RAND_ITEMS     = 850;
  localparam int WATCHDOG_LIMIT = 5000;
  // a load is stored in the same cycle it is taken, so this margin covers it before an APB write
  localparam int LOAD_SETTLE    = 4;
  // longest lookup: full 256-entry scan plus the 32-step divide, with margin
  localparam int END_TAIL       = 320;
  localparam logic [tli_pkg::CFG_ADDR_W-1:0] POINT_COUNT_ADDR =
    tli_pkg::CFG_ADDR_W'(4 * tli_pkg::REG_POINT_COUNT);

  typedef struct {
    logic               action;
    logic [7:0]         entry_index;
    logic signed [31:0] entry_x;
    logic signed [31:0] entry_y;
    logic signed [31:0] query_x;
  } lookup_req_t;

  typedef struct {
    logic signed [31:0] y_value;
    logic               status;
  } lookup_res_t;

  // which branch of the lookup a query took (for the summary only)
  typedef enum int {LK_EMPTY, LK_SINGLE, LK_BELOW, LK_ABOVE, LK_INTERP, LK_KINDS} lookup_kind_e;

  // breakpoint layouts used by the random phases
  typedef enum int {TAB_WIDE, TAB_DENSE, TAB_SCATTER, TAB_GENTLE} table_shape_e;

  // where a random lookup lands relative to the loaded breakpoints
  typedef enum int {
    PICK_ON_POINT, PICK_JUST_ABOVE, PICK_JUST_BELOW, PICK_BETWEEN,
    PICK_ANY, PICK_UNDER_FIRST, PICK_OVER_LAST
  } query_pick_e;

  logic clk_i;
  logic rst_ni;

  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [tli_pkg::CFG_ADDR_W-1:0] paddr;
  logic [31:0]                    pwdata;
  logic [31:0]                    prdata;
  logic                           pready;

  tli_req_if req_bus ();
  tli_rsp_if rsp_bus ();

  table_linear_interpolation uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_bus),
    .rsp_o   (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  lookup_req_t req_backlog[$];       // requests not yet offered to the block
  lookup_res_t pending_results[$];   // predicted results, oldest first

  // predictor's copy of the table (updated on accept) and of point_count
  logic signed [31:0] tab_x [tli_pkg::MAX_POINTS_DEF];
  logic signed [31:0] tab_y [tli_pkg::MAX_POINTS_DEF];
  logic [8:0]         cfg_count;

  // generator's view of the abscissas, runs ahead of the block
  logic signed [31:0] gen_x [tli_pkg::MAX_POINTS_DEF];

  int unsigned pushed_cnt;
  int unsigned accepted_cnt;
  int unsigned n_loads;
  int unsigned n_results;
  int unsigned cfg_writes;
  int unsigned fail_cnt;
  int unsigned kind_hits [LK_KINDS];

  // idling control: request gaps and result stalls in random bursts, rate per phase, off at the end
  bit          gaps_on;
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned quiet_cycles;

  // --------------------------------------------------------------------------
  // Predictor: Q16.16 lookup over the first point_count entries.
  // First entry with x >= q decides: entry 0 -> clamp to y0, none -> clamp
  // to the last y, else interpolate with a 64-bit product and a quotient
  // truncated toward zero (the magnitude of dy is divided, sign reapplied).
  // --------------------------------------------------------------------------
  function automatic lookup_res_t lookup_predict(input logic signed [31:0] q,
                                                 output lookup_kind_e kind);
    lookup_res_t       res;
    int unsigned       n;
    int unsigned       k;
    longint            x0, y0, x1, y1, dy;
    longint unsigned   t, d, mag, quot;
    res.status  = tli_pkg::STATUS_OK;
    res.y_value = '0;
    n = (cfg_count > tli_pkg::MAX_POINTS_DEF) ? tli_pkg::MAX_POINTS_DEF : cfg_count;
    if (n == 0) begin
      res.status = tli_pkg::STATUS_EMPTY;
      kind = LK_EMPTY;
      return res;
    end
    if (n == 1) begin
      res.y_value = tab_y[0];
      kind = LK_SINGLE;
      return res;
    end
    k = 0;
    while (k < n && tab_x[k] < q) k++;
    if (k == n) begin
      res.y_value = tab_y[n-1];
      kind = LK_ABOVE;
    end else if (k == 0) begin
      res.y_value = tab_y[0];
      kind = LK_BELOW;
    end else begin
      // x0 < q <= x1 here, so the divisor is always positive
      x0   = tab_x[k-1];
      y0   = tab_y[k-1];
      x1   = tab_x[k];
      y1   = tab_y[k];
      t    = longint'(q) - x0;
      d    = x1 - x0;
      dy   = y1 - y0;
      mag  = (dy < 0) ? -dy : dy;
      quot = (mag * t) / d;
      res.y_value = 32'((dy < 0) ? y0 - longint'(quot) : y0 + longint'(quot));
      kind = LK_INTERP;
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver. Predicts on accept, then offers the next backlog entry
  // unless an idle burst is running. valid drops during a burst or when nothing is queued.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_requests
    lookup_req_t  nxt;
    lookup_kind_e kind;
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        accepted_cnt++;
        if (req_bus.action == tli_pkg::ACT_LOAD) begin
          tab_x[req_bus.entry_index] = req_bus.entry_x;
          tab_y[req_bus.entry_index] = req_bus.entry_y;
          n_loads++;
        end else begin
          pending_results.push_back(lookup_predict(req_bus.query_x, kind));
          kind_hits[kind]++;
        end
      end
      if (!req_bus.valid || req_bus.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_bus.valid <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          nxt = req_backlog.pop_front();
          req_bus.valid       <= 1'b1;
          req_bus.action      <= nxt.action;
          req_bus.entry_index <= nxt.entry_index;
          req_bus.entry_x     <= nxt.entry_x;
          req_bus.entry_y     <= nxt.entry_y;
          req_bus.query_x     <= nxt.query_x;
          if (gaps_on && $urandom_range(0, 99) < gap_pct) gap_left = $urandom_range(1, 17);
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor with random backpressure bursts.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    lookup_res_t want;
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        n_results++;
        if (pending_results.size() == 0) begin
          $error("result with no lookup outstanding: y_value %0d status %0d",
                 rsp_bus.y_value, rsp_bus.status);
          fail_cnt++;
        end else begin
          want = pending_results.pop_front();
          if (rsp_bus.y_value !== want.y_value) begin
            $error("y_value mismatch: expected %0d, actual %0d", want.y_value, rsp_bus.y_value);
            fail_cnt++;
          end
          if (rsp_bus.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, rsp_bus.status);
            fail_cnt++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
        if (gaps_on && $urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 17);
      end
    end
  end

  // Watchdog: too long without any request, result or APB activity.
  always @(posedge clk_i) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || psel)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: %0d cycles without progress", WATCHDOG_LIMIT);
      $display("[table_linear_interpolation] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_load(input logic [7:0] idx, input logic signed [31:0] x,
                           input logic signed [31:0] y);
    lookup_req_t it;
    it.action      = tli_pkg::ACT_LOAD;
    it.entry_index = idx;
    it.entry_x     = x;
    it.entry_y     = y;
    it.query_x     = $urandom;   // ignored by a load
    gen_x[idx]     = x;
    req_backlog.push_back(it);
    pushed_cnt++;
  endtask

  task automatic push_query(input logic signed [31:0] q);
    lookup_req_t it;
    it.action      = tli_pkg::ACT_QUERY;
    it.entry_index = 8'($urandom);   // entry fields are ignored by a lookup
    it.entry_x     = $urandom;
    it.entry_y     = $urandom;
    it.query_x     = q;
    req_backlog.push_back(it);
    pushed_cnt++;
  endtask

  // every request taken and every predicted result returned
  task automatic wait_drained();
    while (accepted_cnt != pushed_cnt || pending_results.size() != 0) @(posedge clk_i);
  endtask

  // two-phase APB transfer; completes at the edge with penable high
  task automatic apb_access(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= POINT_COUNT_ADDR;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // write point_count while idle (junk in the upper bits at times), read back
  task automatic set_point_count(input logic [8:0] value);
    logic [31:0] rd;
    wait_drained();
    repeat (LOAD_SETTLE) @(posedge clk_i);
    apb_access(1'b1, {($urandom_range(0, 1) != 0) ? 23'($urandom) : 23'd0, value}, rd);
    apb_access(1'b0, $urandom, rd);
    if (rd[8:0] !== value) begin
      $error("point_count readback mismatch: expected %0d, actual %0d", value, rd[8:0]);
      fail_cnt++;
    end
    cfg_count = value;
    cfg_writes++;
  endtask

  // One phase: set the count, optionally load a fresh table over entries
  // 0..count-1 (capped at the table size), then lookups aimed at the breakpoints with a few stray loads.
  // Stray loads only touch entries already in use or beyond the count, so
  // a lookup never scans an entry that was never written.
  task automatic run_phase(input logic [8:0] count, input int unsigned n_queries,
                           input bit fresh, input bit mid_hold);
    int unsigned        used, k, j;
    table_shape_e       shape;
    query_pick_e        pick;
    longint             cur, step_max, lo, hi, q;
    logic signed [31:0] xv, yv;
    used = (count > tli_pkg::MAX_POINTS_DEF) ? tli_pkg::MAX_POINTS_DEF : count;
    set_point_count(count);
    case ($urandom_range(0, 2))
      0:       gap_pct = 0;
      1:       gap_pct = 10;
      default: gap_pct = 35;
    endcase
    stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
    if (!gaps_on) begin
      gap_pct   = 0;
      stall_pct = 0;
    end
    if (fresh && used > 0) begin
      shape    = table_shape_e'($urandom_range(0, 3));
      cur      = -64'sd2147483648 + longint'($urandom_range(0, 32'h7fff_ffff));
      step_max = (64'sd2147483647 - cur) / used;
      for (k = 0; k < used; k++) begin
        if (shape == TAB_SCATTER) begin
          xv = $urandom;
        end else begin
          xv = 32'(cur);
          if (shape == TAB_DENSE) cur += $urandom_range(0, 1 << 18);  // repeats allowed
          else                    cur += 1 + longint'($urandom) % step_max;
        end
        if (shape == TAB_GENTLE) yv = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
        else                     yv = $urandom;
        push_load(8'(k), xv, yv);
      end
    end
    if (mid_hold) wait_drained();
    for (k = 0; k < n_queries; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        if (used > 0 && (used == tli_pkg::MAX_POINTS_DEF || $urandom_range(0, 1) == 0))
          j = $urandom_range(0, used - 1);
        else
          j = $urandom_range(used, tli_pkg::MAX_POINTS_DEF - 1);
        push_load(8'(j), $urandom, $urandom);
      end
      if (used == 0) begin
        q = longint'($signed($urandom));
      end else begin
        j    = $urandom_range(0, used - 1);
        pick = query_pick_e'($urandom_range(0, 6));
        case (pick)
          PICK_ON_POINT:    q = gen_x[j];
          PICK_JUST_ABOVE:  q = longint'(gen_x[j]) + 1;
          PICK_JUST_BELOW:  q = longint'(gen_x[j]) - 1;
          PICK_BETWEEN: begin
            lo = gen_x[j];
            hi = (j + 1 < used) ? longint'(gen_x[j+1]) : lo;
            q  = (hi > lo) ? lo + 1 + longint'($urandom) % (hi - lo) : lo;
          end
          PICK_UNDER_FIRST: q = longint'(gen_x[0]) - $urandom_range(1, 1000);
          PICK_OVER_LAST:   q = longint'(gen_x[used-1]) + $urandom_range(1, 1000);
          default:          q = longint'($signed($urandom));
        endcase
      end
      push_query(32'(q));   // out-of-range picks wrap, which is still a legal query
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned directed_cnt;
    int unsigned sel;
    logic [8:0]  cnt;

    clk_i               = 1'b0;
    rst_ni              = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    req_bus.valid       = 1'b0;
    req_bus.action      = tli_pkg::ACT_LOAD;
    req_bus.entry_index = '0;
    req_bus.entry_x     = '0;
    req_bus.entry_y     = '0;
    req_bus.query_x     = '0;
    rsp_bus.ready       = 1'b0;
    cfg_count           = '0;
    gaps_on             = 1'b1;
    gap_pct             = 30;
    stall_pct           = 30;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // ---- directed: empty table right after reset ----
    push_query(32'sd0);
    push_query(32'sh8000_0000);
    push_load(8'd255, 32'sh7fff_ffff, 32'sh8000_0000);   // load at the top index

    // ---- single entry: always y of entry 0 ----
    set_point_count(9'd1);
    push_load(8'd0, 32'sh8000_0000, 32'sh7fff_ffff);
    push_query(32'sh7fff_ffff);
    push_query(32'sh8000_0000);

    // ---- two entries spanning the full range, steepest slopes ----
    set_point_count(9'd2);
    push_load(8'd1, 32'sh7fff_ffff, 32'sh8000_0000);
    push_query(32'sh8000_0000);    // equal to x0: clamped to y0
    push_query(32'sd0);            // largest divisor
    push_query(32'sh7fff_ffff);    // q equals x1
    push_query(32'sh8000_0001);
    push_load(8'd0, 32'sh8000_0000, 32'sh8000_0000);
    push_load(8'd1, 32'sh7fff_ffff, 32'sh7fff_ffff);
    push_query(32'sd0);
    push_load(8'd1, 32'sd0, 32'sh7fff_ffff);
    push_query(32'sd1);            // above the last x
    push_query(32'sd0);
    // repeated abscissa: a lookup equal to it stops at the first one
    push_load(8'd0, 32'sd5, 32'sd123);
    push_load(8'd1, 32'sd5, -32'sd7);
    push_query(32'sd5);
    push_query(32'sd6);
    push_query(32'sd4);

    // ---- three entries, an ordinary Q16.16 segment ----
    set_point_count(9'd3);
    push_load(8'd2, 32'sd100 <<< 16, -(32'sd50 <<< 16));
    push_query(32'sd50 <<< 16);
    push_query(32'sh7fff_ffff);
    directed_cnt = pushed_cnt;

    // ---- full table, then counts past the table size ----
    run_phase(9'd256, 30, 1'b1, 1'b1);   // sender holds until all results are back
    run_phase(9'd300, 15, 1'b0, 1'b0);
    run_phase(9'd511, 10, 1'b0, 1'b1);

    // ---- random phases, mostly small tables ----
    while (pushed_cnt < directed_cnt + RAND_ITEMS - 60) begin
      sel = $urandom_range(0, 19);
      case (sel)
        0:       cnt = 9'd0;
        1:       cnt = 9'd1;
        2:       cnt = 9'($urandom_range(13, 40));
        default: cnt = 9'($urandom_range(2, 12));
      endcase
      run_phase(cnt, $urandom_range(10, 30), 1'b1, $urandom_range(0, 3) == 0);
    end

    // ---- closing stretch at full rate ----
    gaps_on = 1'b0;
    for (sel = 0; sel < 2; sel++) run_phase(9'($urandom_range(2, 8)), 25, 1'b1, 1'b0);

    wait_drained();
    repeat (END_TAIL) @(posedge clk_i);

    $display("covered %0d loads and %0d lookups across %0d point_count writes",
             n_loads, n_results, cfg_writes);
    $display("lookups: %0d empty, %0d single, %0d below, %0d above, %0d interpolated",
             kind_hits[LK_EMPTY], kind_hits[LK_SINGLE], kind_hits[LK_BELOW],
             kind_hits[LK_ABOVE], kind_hits[LK_INTERP]);
    if (fail_cnt == 0) begin
      $display("[table_linear_interpolation] OK");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("[table_linear_interpolation] ERROR");
    end
    $finish;
  end

endmodule
